// ===== rtl/tocc_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed output channel controller package
// Shared constants, command and register codes, and the channel unit types.
// ----------------------------------------------------------------------------
package tocc_pkg;

    localparam int CHANNELS = 10;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_CH_W = 4;
    localparam int TIME_W   = 16;
    localparam int OUT_W    = 16;

    // input commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_HOST  = 2'd1;
    localparam logic [1:0] CMD_ENTRY = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_G1_RST_CH  = 3'd0;
    localparam logic [2:0] CFG_G1_RST_DLY = 3'd1;
    localparam logic [2:0] CFG_G2_RST_CH  = 3'd2;
    localparam logic [2:0] CFG_G2_RST_DLY = 3'd3;
    localparam logic [2:0] CFG_G1_NORM_CH = 3'd4;
    localparam logic [2:0] CFG_G1_RSV_CH  = 3'd5;
    localparam logic [2:0] CFG_G2_NORM_CH = 3'd6;
    localparam logic [2:0] CFG_G2_RSV_CH  = 3'd7;

    // state of one channel as seen by the shared update unit
    typedef struct packed {
        logic              delay_mode;  // 0: pulse rule, 1: auto-off countdown
        logic              command;
        logic              previous;
        logic              drive;
        logic [TIME_W-1:0] phase;
        logic [TIME_W-1:0] delay_left;
        logic [TIME_W-1:0] begin_t;
        logic [TIME_W-1:0] high_t;
        logic [TIME_W-1:0] low_t;
    } chan_in_t;

    typedef struct packed {
        logic              command;
        logic              previous;
        logic              drive;
        logic [TIME_W-1:0] phase;
        logic [TIME_W-1:0] delay_left;
        logic              expired;
    } chan_out_t;

endpackage

// ===== rtl/tocc_chan_unit.sv =====
// ----------------------------------------------------------------------------
// Channel update unit
// Next state of one channel for either the pulse rule or the auto-off countdown.
// ----------------------------------------------------------------------------
module tocc_chan_unit
    import tocc_pkg::*;
(
    input  chan_in_t  ch_in,
    output chan_out_t ch_out
);

    logic [TIME_W-1:0]   cnt_inc;
    logic [TIME_W+1:0]   sum_on;
    logic [TIME_W+1:0]   sum_period;
    logic [TIME_W+1:0]   cnt_wide;
    logic [TIME_W-1:0]   dly_dec;

    assign cnt_inc    = ch_in.phase + TIME_W'(1);
    assign cnt_wide   = (TIME_W+2)'(cnt_inc);
    assign sum_on     = (TIME_W+2)'(ch_in.begin_t) + (TIME_W+2)'(ch_in.high_t);
    assign sum_period = sum_on + (TIME_W+2)'(ch_in.low_t);
    assign dly_dec    = ch_in.delay_left - TIME_W'(1);

    always_comb
    begin
        ch_out.command    = ch_in.command;
        ch_out.previous   = ch_in.previous;
        ch_out.drive      = ch_in.drive;
        ch_out.phase      = ch_in.phase;
        ch_out.delay_left = ch_in.delay_left;
        ch_out.expired    = 1'b0;

        if (ch_in.delay_mode)
        begin
            if (ch_in.command && (ch_in.delay_left != '0))
            begin
                ch_out.delay_left = dly_dec;
                if (dly_dec == '0)
                begin
                    ch_out.command = 1'b0;
                    ch_out.expired = 1'b1;
                end
            end
        end
        else if (ch_in.begin_t != '0)
        begin
            if (!ch_in.command)
            begin
                ch_out.previous = 1'b0;
                ch_out.drive    = 1'b0;
                ch_out.phase    = '0;
            end
            else if (!ch_in.previous)
            begin
                ch_out.previous = 1'b1;
                ch_out.drive    = 1'b1;
                ch_out.phase    = cnt_inc;
            end
            else
            begin
                ch_out.phase = cnt_inc;
                if ((ch_in.high_t != '0) && (ch_in.low_t != '0))
                begin
                    // pulse train: off after begin+on, restart at begin+on+off
                    if (cnt_wide >= sum_on)
                        ch_out.drive = 1'b0;
                    if (cnt_wide >= sum_period)
                    begin
                        ch_out.drive = 1'b1;
                        ch_out.phase = ch_in.begin_t;
                    end
                end
                else if (ch_in.high_t == '0)
                begin
                    // one-shot
                    if (cnt_inc >= ch_in.begin_t)
                    begin
                        ch_out.drive   = 1'b0;
                        ch_out.command = 1'b0;
                    end
                end
                else
                begin
                    if (cnt_inc >= ch_in.begin_t)
                    begin
                        ch_out.drive = 1'b1;
                        ch_out.phase = ch_in.begin_t;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/timed_output_channel_controller_core.sv =====
// ----------------------------------------------------------------------------
// Timed output channel controller core
// Bank of output channels with pulse rules, auto-off delays and group resets.
// ----------------------------------------------------------------------------
// One channel update unit is stepped over the channels in index order. A tick
// is accepted, runs the pulse rule on each channel in turn, then gives its
// result; on every second tick an auto-off countdown pass over the channels
// comes before the result. Host and entry commands go straight to the result.
// One result transaction follows every input transaction; the next input is
// taken while that result still waits on out_stall.
module timed_output_channel_controller_core
    import tocc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [15:0]       off_mask,
    input  logic [15:0]       on_mask,
    input  logic [15:0]       on_delay,
    input  logic [3:0]        entry_channel,
    input  logic [15:0]       begin_ticks,
    input  logic [15:0]       high_ticks,
    input  logic [15:0]       low_ticks,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  drive_bits,
    output logic [OUT_W-1:0]  command_off_bits
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PULSE  = 4'b0010,
        S_DELAY  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    localparam logic [CH_IDX_W-1:0] IDX_LAST = CH_IDX_W'(CHANNELS - 1);

    state_t               state_reg, state_next;
    logic [CH_IDX_W-1:0]  idx_reg, idx_next;
    logic                 parity_reg;

    logic [CFG_CH_W-1:0]  g1_rst_ch_reg, g2_rst_ch_reg;
    logic [TIME_W-1:0]    g1_rst_dly_reg, g2_rst_dly_reg;
    logic [CFG_CH_W-1:0]  g1_norm_ch_reg, g1_rsv_ch_reg;
    logic [CFG_CH_W-1:0]  g2_norm_ch_reg, g2_rsv_ch_reg;

    logic [CHANNELS-1:0]  command_reg;
    logic [CHANNELS-1:0]  previous_reg;
    logic [CHANNELS-1:0]  drive_reg;
    logic [TIME_W-1:0]    phase_reg   [CHANNELS];
    logic [TIME_W-1:0]    delay_reg   [CHANNELS];
    logic [TIME_W-1:0]    begin_reg   [CHANNELS];
    logic [TIME_W-1:0]    high_reg    [CHANNELS];
    logic [TIME_W-1:0]    low_reg     [CHANNELS];

    logic [CHANNELS-1:0]  command_next;
    logic [TIME_W-1:0]    delay_next  [CHANNELS];

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     drive_out_reg;
    logic [OUT_W-1:0]     off_out_reg;
    logic [CHANNELS-1:0]  off_now;

    chan_in_t             unit_in;
    chan_out_t            unit_out;

    logic                 in_accept;
    logic                 out_free;
    logic                 step_en;
    logic [CFG_CH_W-1:0]  idx_wide;
    logic                 g1_hit, g2_hit;
    logic                 rst_start;
    logic [CFG_CH_W-1:0]  rst_ch;
    logic [TIME_W-1:0]    rst_dly;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_en   = (state_reg == S_PULSE) || (state_reg == S_DELAY);
    assign off_now   = ~command_reg;

    assign out_valid        = out_valid_reg;
    assign drive_bits       = drive_out_reg;
    assign command_off_bits = off_out_reg;

    // ---- shared channel unit ----
    always_comb
    begin
        unit_in.delay_mode = (state_reg == S_DELAY);
        unit_in.command    = command_reg[idx_reg];
        unit_in.previous   = previous_reg[idx_reg];
        unit_in.drive      = drive_reg[idx_reg];
        unit_in.phase      = phase_reg[idx_reg];
        unit_in.delay_left = delay_reg[idx_reg];
        unit_in.begin_t    = begin_reg[idx_reg];
        unit_in.high_t     = high_reg[idx_reg];
        unit_in.low_t      = low_reg[idx_reg];
    end

    tocc_chan_unit u_chan_unit (
        .ch_in  (unit_in),
        .ch_out (unit_out)
    );

    // ---- group reset start on expiry, group 1 first ----
    always_comb
    begin
        idx_wide  = CFG_CH_W'(idx_reg);
        g1_hit    = (idx_wide == g1_norm_ch_reg) || (idx_wide == g1_rsv_ch_reg);
        g2_hit    = (idx_wide == g2_norm_ch_reg) || (idx_wide == g2_rsv_ch_reg);
        rst_ch    = g1_hit ? g1_rst_ch_reg  : g2_rst_ch_reg;
        rst_dly   = g1_hit ? g1_rst_dly_reg : g2_rst_dly_reg;
        rst_start = (state_reg == S_DELAY) && unit_out.expired && (g1_hit || g2_hit)
                    && ((CFG_CH_W+1)'(rst_ch) < (CFG_CH_W+1)'(CHANNELS));
    end

    // ---- per-step command and delay update ----
    always_comb
    begin
        command_next = command_reg;
        for (int i = 0; i < CHANNELS; i++)
            delay_next[i] = delay_reg[i];
        command_next[idx_reg] = unit_out.command;
        delay_next[idx_reg]   = unit_out.delay_left;
        // reset channel start wins over the expiring channel's own update
        if (rst_start)
        begin
            command_next[rst_ch[CH_IDX_W-1:0]] = 1'b1;
            delay_next[rst_ch[CH_IDX_W-1:0]]   = rst_dly;
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = '0;
                    state_next = (cmd == CMD_TICK) ? S_PULSE : S_FINISH;
                end
            end
            S_PULSE:
            begin
                idx_next = idx_reg + CH_IDX_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = parity_reg ? S_DELAY : S_FINISH;
                end
            end
            S_DELAY:
            begin
                idx_next = idx_reg + CH_IDX_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            parity_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if ((state_reg == S_PULSE) && (idx_reg == IDX_LAST))
                parity_reg <= !parity_reg;
        end
    end

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_rst_ch_reg  <= '1;
            g1_rst_dly_reg <= '0;
            g2_rst_ch_reg  <= '1;
            g2_rst_dly_reg <= '0;
            g1_norm_ch_reg <= '1;
            g1_rsv_ch_reg  <= '1;
            g2_norm_ch_reg <= '1;
            g2_rsv_ch_reg  <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_G1_RST_CH:  g1_rst_ch_reg  <= cfg_data[CFG_CH_W-1:0];
                CFG_G1_RST_DLY: g1_rst_dly_reg <= cfg_data;
                CFG_G2_RST_CH:  g2_rst_ch_reg  <= cfg_data[CFG_CH_W-1:0];
                CFG_G2_RST_DLY: g2_rst_dly_reg <= cfg_data;
                CFG_G1_NORM_CH: g1_norm_ch_reg <= cfg_data[CFG_CH_W-1:0];
                CFG_G1_RSV_CH:  g1_rsv_ch_reg  <= cfg_data[CFG_CH_W-1:0];
                CFG_G2_NORM_CH: g2_norm_ch_reg <= cfg_data[CFG_CH_W-1:0];
                CFG_G2_RSV_CH:  g2_rsv_ch_reg  <= cfg_data[CFG_CH_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---- channel state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg  <= '0;
            previous_reg <= '0;
            drive_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                phase_reg[i] <= '0;
                delay_reg[i] <= '0;
                begin_reg[i] <= '0;
                high_reg[i]  <= '0;
                low_reg[i]   <= '0;
            end
        end
        else
        begin
            if (in_accept && (cmd == CMD_HOST))
            begin
                command_reg <= (command_reg & ~off_mask[CHANNELS-1:0])
                               | on_mask[CHANNELS-1:0];
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (on_mask[i])
                        delay_reg[i] <= on_delay;
                end
            end
            else if (step_en)
            begin
                command_reg           <= command_next;
                previous_reg[idx_reg] <= unit_out.previous;
                drive_reg[idx_reg]    <= unit_out.drive;
                phase_reg[idx_reg]    <= unit_out.phase;
                for (int i = 0; i < CHANNELS; i++)
                    delay_reg[i] <= delay_next[i];
            end

            if (in_accept && (cmd == CMD_ENTRY)
                && ((CFG_CH_W+1)'(entry_channel) < (CFG_CH_W+1)'(CHANNELS)))
            begin
                begin_reg[entry_channel[CH_IDX_W-1:0]] <= begin_ticks;
                high_reg[entry_channel[CH_IDX_W-1:0]]  <= high_ticks;
                low_reg[entry_channel[CH_IDX_W-1:0]]   <= low_ticks;
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == S_FINISH) && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FINISH) && out_free)
        begin
            drive_out_reg <= OUT_W'(drive_reg);
            off_out_reg   <= OUT_W'(off_now);
        end
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> ((CH_IDX_W+1)'(idx_reg) < (CH_IDX_W+1)'(CHANNELS)))
        else $error("channel index out of range");

    a_delay_after_odd_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELAY) |-> !parity_reg)
        else $error("countdown pass with parity still set");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> (state_reg != S_IDLE))
        else $error("accepted transaction not started");
`endif

endmodule

// ===== tb/sv/channel_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// Channel bank scoreboard
// Tracks channel commands, pulse phases and auto-off countdowns of the
// output channel bank and checks every status transaction in order.
// ----------------------------------------------------------------------------
package channel_scoreboard_pkg;

    import tocc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] drive;
        logic [OUT_W-1:0] off;
    } bank_status_t;

    class channel_scoreboard;

        // group settings, index 0 is group 1
        bit [CFG_CH_W-1:0] reset_ch   [2];
        bit [TIME_W-1:0]   reset_dly  [2];
        bit [CFG_CH_W-1:0] normal_ch  [2];
        bit [CFG_CH_W-1:0] reserve_ch [2];

        bit              cmd_on   [16];
        bit              prev_on  [16];
        bit              drv      [16];
        bit [TIME_W-1:0] phase    [16];
        bit [TIME_W-1:0] left     [16];
        bit [TIME_W-1:0] t_begin  [16];
        bit [TIME_W-1:0] t_high   [16];
        bit [TIME_W-1:0] t_low    [16];
        bit              parity;

        bank_status_t expected_status [$];
        int errors;

        function new();
            for (int g = 0; g < 2; g++)
            begin
                reset_ch[g]   = 4'd15;
                reset_dly[g]  = '0;
                normal_ch[g]  = 4'd15;
                reserve_ch[g] = 4'd15;
            end
            for (int i = 0; i < 16; i++)
            begin
                cmd_on[i]  = 1'b0;
                prev_on[i] = 1'b0;
                drv[i]     = 1'b0;
                phase[i]   = '0;
                left[i]    = '0;
                t_begin[i] = '0;
                t_high[i]  = '0;
                t_low[i]   = '0;
            end
            parity = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_G1_RST_CH:  reset_ch[0]   = data[3:0];
                CFG_G1_RST_DLY: reset_dly[0]  = data;
                CFG_G2_RST_CH:  reset_ch[1]   = data[3:0];
                CFG_G2_RST_DLY: reset_dly[1]  = data;
                CFG_G1_NORM_CH: normal_ch[0]  = data[3:0];
                CFG_G1_RSV_CH:  reserve_ch[0] = data[3:0];
                CFG_G2_NORM_CH: normal_ch[1]  = data[3:0];
                CFG_G2_RSV_CH:  reserve_ch[1] = data[3:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void run_pulse_rules();
            logic [17:0] count;
            logic [17:0] on_end;
            logic [17:0] cycle_end;
            logic [17:0] start;
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (t_begin[i] == 0)
                    continue;
                start     = {2'b00, t_begin[i]};
                on_end    = start + {2'b00, t_high[i]};
                cycle_end = on_end + {2'b00, t_low[i]};
                if (!cmd_on[i])
                begin
                    prev_on[i] = 1'b0;
                    drv[i]     = 1'b0;
                    phase[i]   = '0;
                end
                else if (!prev_on[i])
                begin
                    prev_on[i] = 1'b1;
                    drv[i]     = 1'b1;
                    phase[i]   = phase[i] + 1'b1;
                end
                else
                begin
                    phase[i] = phase[i] + 1'b1;
                    count    = {2'b00, phase[i]};
                    if (t_high[i] != 0 && t_low[i] != 0)
                    begin
                        if (count >= on_end)
                            drv[i] = 1'b0;
                        if (count >= cycle_end)
                        begin
                            drv[i]   = 1'b1;
                            phase[i] = t_begin[i];
                        end
                    end
                    else if (t_high[i] == 0)
                    begin
                        // one-shot drops its own command
                        if (count >= start)
                        begin
                            drv[i]    = 1'b0;
                            cmd_on[i] = 1'b0;
                        end
                    end
                    else if (count >= start)
                    begin
                        drv[i]   = 1'b1;
                        phase[i] = t_begin[i];
                    end
                end
            end
        endfunction

        function void start_reset(int g);
            if (reset_ch[g] < CHANNELS)
            begin
                left[reset_ch[g]]   = reset_dly[g];
                cmd_on[reset_ch[g]] = 1'b1;
            end
        endfunction

        function void run_countdown();
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (!cmd_on[i] || left[i] == 0)
                    continue;
                left[i] = left[i] - 1'b1;
                if (left[i] != 0)
                    continue;
                cmd_on[i] = 1'b0;
                // group 1 wins when a channel sits in both groups
                if (i == normal_ch[0] || i == reserve_ch[0])
                    start_reset(0);
                else if (i == normal_ch[1] || i == reserve_ch[1])
                    start_reset(1);
            end
        endfunction

        function void apply_input(logic [1:0] c, logic [15:0] offm, logic [15:0] onm,
                                  logic [15:0] dly, logic [3:0] ch, logic [15:0] b,
                                  logic [15:0] h, logic [15:0] l);
            bank_status_t st;
            case (c)
                CMD_TICK:
                begin
                    run_pulse_rules();
                    if (!parity)
                        parity = 1'b1;
                    else
                    begin
                        parity = 1'b0;
                        run_countdown();
                    end
                end
                CMD_HOST:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        if (offm[i])
                            cmd_on[i] = 1'b0;
                    for (int i = 0; i < CHANNELS; i++)
                        if (onm[i])
                        begin
                            left[i]   = dly;
                            cmd_on[i] = 1'b1;
                        end
                end
                CMD_ENTRY:
                begin
                    if (ch < CHANNELS)
                    begin
                        t_begin[ch] = b;
                        t_high[ch]  = h;
                        t_low[ch]   = l;
                    end
                end
                default: ;
            endcase
            st = '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                st.drive[i] = drv[i];
                st.off[i]   = !cmd_on[i];
            end
            expected_status.push_back(st);
        endfunction

        function void check_status(logic [OUT_W-1:0] drive, logic [OUT_W-1:0] off);
            bank_status_t want;
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected status transaction, drive_bits %h command_off_bits %h",
                         $time, drive, off);
                errors++;
                return;
            end
            want = expected_status.pop_front();
            if (drive !== want.drive)
            begin
                $display("%0t: drive_bits expected %h actual %h", $time, want.drive, drive);
                errors++;
            end
            if (off !== want.off)
            begin
                $display("%0t: command_off_bits expected %h actual %h", $time, want.off, off);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/timed_output_channel_controller_core_test.sv =====
// ----------------------------------------------------------------------------
// Timed output channel controller core testbench
// Directed and random ticks, host commands and timing entries under several
// group settings, with random idling on both channels; every status
// transaction is checked against a cycle-free model of the channel bank.
// ----------------------------------------------------------------------------
module timed_output_channel_controller_core_test;

    import tocc_pkg::*;
    import channel_scoreboard_pkg::*;

    localparam int           RANDOM_ITEMS = 850;
    localparam int           PHASES       = 4;
    localparam int           SETTLE       = 40;
    localparam int unsigned  LIMIT        = 600000;
    localparam logic [1:0]   CMD_UNUSED   = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [15:0]       cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        cmd;
    logic [15:0]       off_mask;
    logic [15:0]       on_mask;
    logic [15:0]       on_delay;
    logic [3:0]        entry_channel;
    logic [15:0]       begin_ticks;
    logic [15:0]       high_ticks;
    logic [15:0]       low_ticks;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [OUT_W-1:0]  drive_bits;
    logic [OUT_W-1:0]  command_off_bits;

    channel_scoreboard bank;
    logic [15:0]       reg_plan [8];
    int                rx_hold = 0;
    bit                tx_quiet = 1'b0;
    bit                rx_quiet = 1'b0;
    int unsigned       cycles = 0;

    timed_output_channel_controller_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .off_mask         (off_mask),
        .on_mask          (on_mask),
        .on_delay         (on_delay),
        .entry_channel    (entry_channel),
        .begin_ticks      (begin_ticks),
        .high_ticks       (high_ticks),
        .low_ticks        (low_ticks),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_bits       (drive_bits),
        .command_off_bits (command_off_bits)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // status side: check accepted transactions, then pick the next stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            bank.check_status(drive_bits, command_off_bits);
        if (rx_hold == 0 && !rx_quiet)
            rx_hold = pick_gap();
        if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [15:0] short_time(int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 16'($urandom_range(0, hi));
        else if (r < 95)
            return 16'($urandom);
        return 16'hFFFF;
    endfunction

    // style 0 random, 1 channel 0 with the longest delay, 2 disabled with no delay
    function automatic logic [15:0] chan_value(int style);
        logic [15:0] v;
        v = 16'($urandom);
        if (style == 1)
            v[3:0] = 4'd0;
        else if (style == 2)
            v[3:0] = 4'd15;
        else if ($urandom_range(0, 4) != 0)
            v[3:0] = 4'($urandom_range(0, CHANNELS - 1));
        return v;
    endfunction

    function automatic logic [15:0] delay_value(int style);
        int r;
        if (style == 1)
            return 16'hFFFF;
        else if (style == 2)
            return 16'h0000;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'($urandom_range(0, 8));
        else if (r < 9)
            return 16'($urandom);
        return 16'hFFFF;
    endfunction

    task automatic plan_config(input int style);
        reg_plan[CFG_G1_RST_CH]  = chan_value(style);
        reg_plan[CFG_G1_RST_DLY] = delay_value(style);
        reg_plan[CFG_G2_RST_CH]  = chan_value(style);
        reg_plan[CFG_G2_RST_DLY] = delay_value(style);
        reg_plan[CFG_G1_NORM_CH] = chan_value(style);
        reg_plan[CFG_G1_RSV_CH]  = chan_value(style);
        reg_plan[CFG_G2_NORM_CH] = chan_value(style);
        reg_plan[CFG_G2_RSV_CH]  = chan_value(style);
    endtask

    task automatic configure();
        for (int k = 0; k < 8; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= k[2:0];
            cfg_data  <= reg_plan[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            bank.write_reg(k[2:0], reg_plan[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic sender_gap();
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [1:0] c, input logic [15:0] offm,
                             input logic [15:0] onm, input logic [15:0] dly,
                             input logic [3:0] ch, input logic [15:0] b,
                             input logic [15:0] h, input logic [15:0] l);
        in_valid      <= 1'b1;
        cmd           <= c;
        off_mask      <= offm;
        on_mask       <= onm;
        on_delay      <= dly;
        entry_channel <= ch;
        begin_ticks   <= b;
        high_ticks    <= h;
        low_ticks     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bank.apply_input(c, offm, onm, dly, ch, b, h, l);
        sender_gap();
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // hold off the sender until every status transaction is back
    task automatic drain();
        in_valid <= 1'b0;
        while (bank.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int          counted;
        int          kind;
        logic [1:0]  c;
        logic [15:0] offm, onm, dly, b, h, l;
        logic [3:0]  ch;

        bank = new();
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        cmd           <= CMD_TICK;
        off_mask      <= '0;
        on_mask       <= '0;
        on_delay      <= '0;
        entry_channel <= '0;
        begin_ticks   <= '0;
        high_ticks    <= '0;
        low_ticks     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // channel 1 sits in both groups; group 1 reset target is above its triggers
        reg_plan[CFG_G1_RST_CH]  = 16'd4;
        reg_plan[CFG_G1_RST_DLY] = 16'd0;
        reg_plan[CFG_G2_RST_CH]  = 16'd6;
        reg_plan[CFG_G2_RST_DLY] = 16'd3;
        reg_plan[CFG_G1_NORM_CH] = 16'd0;
        reg_plan[CFG_G1_RSV_CH]  = 16'd1;
        reg_plan[CFG_G2_NORM_CH] = 16'd1;
        reg_plan[CFG_G2_RSV_CH]  = 16'd3;
        configure();

        send_item(CMD_ENTRY, 16'h0, 16'h0, 16'h0, 4'd0, 16'd2, 16'd2, 16'd3);
        send_item(CMD_ENTRY, 16'h0, 16'h0, 16'h0, 4'd1, 16'd3, 16'd0, 16'd5);
        send_item(CMD_ENTRY, 16'h0, 16'h0, 16'h0, 4'd2, 16'd1, 16'd4, 16'd0);
        send_item(CMD_ENTRY, 16'h0, 16'h0, 16'h0, 4'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_ENTRY, 16'h0, 16'h0, 16'h0, 4'd6, 16'd2, 16'd1, 16'd1);
        send_item(CMD_ENTRY, 16'h0, 16'h0, 16'h0, 4'd9, 16'd1, 16'd1, 16'd1);
        // channel outside the bank: write dropped
        send_item(CMD_ENTRY, 16'h0, 16'h0, 16'h0, 4'd15, 16'd7, 16'd7, 16'd7);
        send_item(CMD_HOST, 16'h0000, 16'hFFFF, 16'd4, 4'd0, 16'h0, 16'h0, 16'h0);
        repeat (12) send_tick();
        send_item(CMD_HOST, 16'hFFFF, 16'h0004, 16'd0, 4'd0, 16'h0, 16'h0, 16'h0);
        send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15,
                  16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (4) send_tick();
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            plan_config(ph == 0 ? 1 : (ph == 1 ? 2 : 0));
            configure();
            counted = 0;
            while (counted < RANDOM_ITEMS / PHASES)
            begin
                if (counted % 50 == 0)
                begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                kind = $urandom_range(0, 99);
                offm = 16'($urandom);
                onm  = 16'($urandom);
                dly  = 16'($urandom);
                ch   = 4'($urandom);
                b    = 16'($urandom);
                h    = 16'($urandom);
                l    = 16'($urandom);
                if (kind < 66)
                    c = CMD_TICK;
                else if (kind < 78)
                begin
                    c = CMD_HOST;
                    offm = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                           : (offm & 16'($urandom));
                    onm  = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                           : (onm & 16'($urandom) & 16'($urandom));
                    dly  = short_time(20);
                end
                else if (kind < 93)
                begin
                    c  = CMD_ENTRY;
                    ch = 4'($urandom_range(0, 15));
                    b  = short_time(6);
                    h  = short_time(5);
                    l  = short_time(5);
                end
                else
                    c = CMD_UNUSED;
                send_item(c, offm, onm, dly, ch, b, h, l);
                counted++;
            end
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            drain();
        end

        if (bank.errors == 0 && bank.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tocc_pkg.sv
rtl/tocc_chan_unit.sv
rtl/timed_output_channel_controller_core.sv
tb/sv/channel_scoreboard_pkg.sv
tb/sv/timed_output_channel_controller_core_test.sv
